>>> sv/nhs_pkg.sv
// Package: shared widths, codes, control word type and microcode table.
package nhs_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned PC_W     = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_VISIT   = 2'd0,
    CMD_BACK    = 2'd1,
    CMD_FORWARD = 2'd2,
    CMD_DELETE  = 2'd3
  } nhs_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_PREV = 3'd1,
    ST_NO_FWD  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } nhs_status_e;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_VISIT,
    UOP_BACK,
    UOP_FORWARD,
    UOP_DEL_START,
    UOP_SHIFT_RD,
    UOP_SHIFT_WR,
    UOP_DEL_FIN,
    UOP_READ_CUR,
    UOP_RESPOND
  } nhs_uop_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DISPATCH,
    COND_EMPTY,
    COND_NO_NEXT,
    COND_OUT_BUSY
  } nhs_cond_e;

  typedef struct packed {
    nhs_uop_e         uop;
    nhs_cond_e        cond;
    logic [PC_W-1:0]  target;
  } nhs_ucode_t;

  typedef struct packed {
    logic empty;
    logic no_next;
    logic out_busy;
  } nhs_flags_t;

  localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] PC_VISIT     = 4'd1;
  localparam logic [PC_W-1:0] PC_BACK      = 4'd2;
  localparam logic [PC_W-1:0] PC_FORWARD   = 4'd3;
  localparam logic [PC_W-1:0] PC_DEL_START = 4'd4;
  localparam logic [PC_W-1:0] PC_SHIFT_RD  = 4'd5;
  localparam logic [PC_W-1:0] PC_SHIFT_WR  = 4'd6;
  localparam logic [PC_W-1:0] PC_DEL_FIN   = 4'd7;
  localparam logic [PC_W-1:0] PC_READ_CUR  = 4'd8;
  localparam logic [PC_W-1:0] PC_RESPOND   = 4'd9;

  function automatic nhs_ucode_t nhs_ucode(input logic [PC_W-1:0] pc);
    nhs_ucode_t w;
    case (pc)
      PC_IDLE:      w = '{UOP_NOP,       COND_DISPATCH, PC_IDLE};
      PC_VISIT:     w = '{UOP_VISIT,     COND_ALWAYS,   PC_READ_CUR};
      PC_BACK:      w = '{UOP_BACK,      COND_ALWAYS,   PC_READ_CUR};
      PC_FORWARD:   w = '{UOP_FORWARD,   COND_ALWAYS,   PC_READ_CUR};
      PC_DEL_START: w = '{UOP_DEL_START, COND_EMPTY,    PC_READ_CUR};
      PC_SHIFT_RD:  w = '{UOP_SHIFT_RD,  COND_NO_NEXT,  PC_DEL_FIN};
      PC_SHIFT_WR:  w = '{UOP_SHIFT_WR,  COND_ALWAYS,   PC_SHIFT_RD};
      PC_DEL_FIN:   w = '{UOP_DEL_FIN,   COND_NEXT,     PC_IDLE};
      PC_READ_CUR:  w = '{UOP_READ_CUR,  COND_OUT_BUSY, PC_READ_CUR};
      PC_RESPOND:   w = '{UOP_RESPOND,   COND_ALWAYS,   PC_IDLE};
      default:      w = '{UOP_NOP,       COND_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] nhs_dispatch(input nhs_cmd_e cmd);
    logic [PC_W-1:0] pc;
    case (cmd)
      CMD_VISIT:   pc = PC_VISIT;
      CMD_BACK:    pc = PC_BACK;
      CMD_FORWARD: pc = PC_FORWARD;
      CMD_DELETE:  pc = PC_DEL_START;
      default:     pc = PC_IDLE;
    endcase
    return pc;
  endfunction

endpackage

>>> sv/nhs_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface nhs_req_if;
  logic                        valid;
  logic                        ready;
  logic [nhs_pkg::CMD_W-1:0]   command;
  logic [nhs_pkg::TAG_W-1:0]   page_tag;
  logic [nhs_pkg::HOUR_W-1:0]  visit_hour;
  logic [nhs_pkg::MIN_W-1:0]   visit_minute;
  logic [nhs_pkg::SEC_W-1:0]   visit_second;

  modport source (output valid, command, page_tag, visit_hour, visit_minute, visit_second,
                  input ready);
  modport sink   (input valid, command, page_tag, visit_hour, visit_minute, visit_second,
                  output ready);
endinterface

interface nhs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [nhs_pkg::STATUS_W-1:0]  status;
  logic                          cur_valid;
  logic [nhs_pkg::TAG_W-1:0]     cur_tag;
  logic [nhs_pkg::HOUR_W-1:0]    cur_hour;
  logic [nhs_pkg::MIN_W-1:0]     cur_minute;
  logic [nhs_pkg::SEC_W-1:0]     cur_second;
  logic [nhs_pkg::POS_W-1:0]     cursor_pos;
  logic [nhs_pkg::CNT_W-1:0]     entry_count;

  modport source (output valid, status, cur_valid, cur_tag, cur_hour, cur_minute, cur_second,
                  cursor_pos, entry_count, input ready);
  modport sink   (input valid, status, cur_valid, cur_tag, cur_hour, cur_minute, cur_second,
                  cursor_pos, entry_count, output ready);
endinterface

>>> sv/navigation_history_stack.sv
// Top level: bounded back/forward navigation history with a cursor.
// Usage:
//   req_i carries one request per valid/ready handshake: command (visit, back,
//   forward, delete current entry), page tag and visit time. rsp_o returns one
//   response per request: status, the current entry after the request, the
//   cursor position and the number of entries held.
//   A request is taken only while the sequencer waits in its idle step.
// Sequencing:
//   Visit, back, forward and delete on an empty history run their command step,
//   the read step and the respond step; the next request is taken in the cycle
//   the response appears.
//   Delete on a non-empty history moves each entry after the cursor down
//   through the entry memory, one read step and one write step per entry,
//   then finishes, reads the current entry and responds.
// Reset:
//   rst_ni clears the cursor, entry count, shift index, status and response
//   valid flag; memory contents stay as they were and are only read once written.
// Stall:
//   The response register holds its response until rsp_o.ready; the next
//   request proceeds and waits in its read step while the register is full.
module navigation_history_stack #(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned TAG_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nhs_req_if.sink     req_i,
  nhs_rsp_if.source   rsp_o
);

  nhs_pkg::nhs_flags_t flags;
  nhs_pkg::nhs_uop_e   uop;
  logic                req_ready;
  logic                req_take;

  assign req_i.ready = req_ready;
  assign req_take    = req_i.valid && req_ready;

  nhs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.command),
    .flags_i     (flags),
    .req_ready_o (req_ready),
    .uop_o       (uop)
  );

  nhs_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TAG_BITS      (TAG_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .uop_i             (uop),
    .req_take_i        (req_take),
    .req_tag_i         (req_i.page_tag),
    .req_hour_i        (req_i.visit_hour),
    .req_minute_i      (req_i.visit_minute),
    .req_second_i      (req_i.visit_second),
    .rsp_ready_i       (rsp_o.ready),
    .flags_o           (flags),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_status_o      (rsp_o.status),
    .rsp_cur_valid_o   (rsp_o.cur_valid),
    .rsp_cur_tag_o     (rsp_o.cur_tag),
    .rsp_cur_hour_o    (rsp_o.cur_hour),
    .rsp_cur_minute_o  (rsp_o.cur_minute),
    .rsp_cur_second_o  (rsp_o.cur_second),
    .rsp_cursor_pos_o  (rsp_o.cursor_pos),
    .rsp_entry_count_o (rsp_o.entry_count)
  );

endmodule

>>> sv/nhs_seq.sv
// Sequencer: step counter over the microcode table with conditional jumps.
module nhs_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic [nhs_pkg::CMD_W-1:0]     req_cmd_i,
  input  nhs_pkg::nhs_flags_t           flags_i,
  output logic                          req_ready_o,
  output nhs_pkg::nhs_uop_e             uop_o
);

  logic [nhs_pkg::PC_W-1:0] pc_q, pc_d;
  nhs_pkg::nhs_ucode_t      cw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= nhs_pkg::PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_comb begin
    cw          = nhs_pkg::nhs_ucode(pc_q);
    uop_o       = cw.uop;
    req_ready_o = (cw.cond == nhs_pkg::COND_DISPATCH);
    pc_d        = pc_q + 4'd1;
    case (cw.cond)
      nhs_pkg::COND_NEXT:     pc_d = pc_q + 4'd1;
      nhs_pkg::COND_ALWAYS:   pc_d = cw.target;
      nhs_pkg::COND_DISPATCH: begin
        if (req_valid_i) begin
          pc_d = nhs_pkg::nhs_dispatch(nhs_pkg::nhs_cmd_e'(req_cmd_i));
        end else begin
          pc_d = pc_q;
        end
      end
      nhs_pkg::COND_EMPTY:    if (flags_i.empty) pc_d = cw.target;
      nhs_pkg::COND_NO_NEXT:  if (flags_i.no_next) pc_d = cw.target;
      nhs_pkg::COND_OUT_BUSY: if (flags_i.out_busy) pc_d = cw.target;
      default:                pc_d = nhs_pkg::PC_IDLE;
    endcase
  end

endmodule

>>> sv/nhs_dp.sv
// Datapath: entry memory, cursor, count, shift index and response register.
module nhs_dp #(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned TAG_BITS      = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nhs_pkg::nhs_uop_e              uop_i,
  input  logic                           req_take_i,
  input  logic [nhs_pkg::TAG_W-1:0]      req_tag_i,
  input  logic [nhs_pkg::HOUR_W-1:0]     req_hour_i,
  input  logic [nhs_pkg::MIN_W-1:0]      req_minute_i,
  input  logic [nhs_pkg::SEC_W-1:0]      req_second_i,
  input  logic                           rsp_ready_i,
  output nhs_pkg::nhs_flags_t            flags_o,
  output logic                           rsp_valid_o,
  output logic [nhs_pkg::STATUS_W-1:0]   rsp_status_o,
  output logic                           rsp_cur_valid_o,
  output logic [nhs_pkg::TAG_W-1:0]      rsp_cur_tag_o,
  output logic [nhs_pkg::HOUR_W-1:0]     rsp_cur_hour_o,
  output logic [nhs_pkg::MIN_W-1:0]      rsp_cur_minute_o,
  output logic [nhs_pkg::SEC_W-1:0]      rsp_cur_second_o,
  output logic [nhs_pkg::POS_W-1:0]      rsp_cursor_pos_o,
  output logic [nhs_pkg::CNT_W-1:0]      rsp_entry_count_o
);

  localparam int unsigned CW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned NW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned TIME_W = nhs_pkg::HOUR_W + nhs_pkg::MIN_W + nhs_pkg::SEC_W;
  localparam int unsigned EW   = TAG_BITS + TIME_W;

  logic [EW-1:0]  mem_q [HISTORY_DEPTH];
  logic [EW-1:0]  rdata_q;
  logic [CW-1:0]  rd_addr;
  logic           wr_en;
  logic [CW-1:0]  wr_addr;
  logic [EW-1:0]  wr_data;

  logic [CW-1:0]  cursor_q, cursor_d;
  logic [NW-1:0]  count_q, count_d;
  logic [CW-1:0]  idx_q, idx_d;
  nhs_pkg::nhs_status_e status_q, status_d;

  logic [TAG_BITS-1:0]          tag_q;
  logic [nhs_pkg::HOUR_W-1:0]   hour_q;
  logic [nhs_pkg::MIN_W-1:0]    minute_q;
  logic [nhs_pkg::SEC_W-1:0]    second_q;
  logic [47:0]                  tag_in_ext;
  logic [47:0]                  tag_out_ext;

  logic                         rsp_valid_q, rsp_valid_d;
  logic [nhs_pkg::STATUS_W-1:0] rsp_status_q;
  logic                         rsp_cur_valid_q;
  logic [nhs_pkg::TAG_W-1:0]    rsp_tag_q;
  logic [nhs_pkg::HOUR_W-1:0]   rsp_hour_q;
  logic [nhs_pkg::MIN_W-1:0]    rsp_minute_q;
  logic [nhs_pkg::SEC_W-1:0]    rsp_second_q;
  logic [nhs_pkg::POS_W-1:0]    rsp_pos_q;
  logic [nhs_pkg::CNT_W-1:0]    rsp_count_q;
  logic                         rsp_load;

  logic [NW-1:0]  keep;
  logic [NW-1:0]  cursor_ext;
  logic [NW-1:0]  idx_next;
  logic [15:0]    pos_ext;
  logic [15:0]    cnt_ext;

  assign tag_in_ext  = 48'(req_tag_i);
  assign tag_out_ext = 48'(rdata_q[EW-1:TIME_W]);
  assign cursor_ext  = NW'(cursor_q);
  assign idx_next    = NW'(idx_q) + NW'(1);
  assign keep        = (count_q == '0) ? '0 : cursor_ext + NW'(1);
  assign pos_ext     = 16'(cursor_q);
  assign cnt_ext     = 16'(count_q);

  // Request payload hold
  always_ff @(posedge clk_i) begin
    if (req_take_i) begin
      tag_q    <= tag_in_ext[TAG_BITS-1:0];
      hour_q   <= req_hour_i;
      minute_q <= req_minute_i;
      second_q <= req_second_i;
    end
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      status_q    <= nhs_pkg::ST_OK;
      rsp_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      status_q    <= status_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_status_q    <= status_q;
      rsp_count_q     <= cnt_ext[nhs_pkg::CNT_W-1:0];
      if (count_q != '0) begin
        rsp_cur_valid_q <= 1'b1;
        rsp_tag_q       <= tag_out_ext[nhs_pkg::TAG_W-1:0];
        rsp_hour_q      <= rdata_q[TIME_W-1 -: nhs_pkg::HOUR_W];
        rsp_minute_q    <= rdata_q[nhs_pkg::SEC_W +: nhs_pkg::MIN_W];
        rsp_second_q    <= rdata_q[nhs_pkg::SEC_W-1:0];
        rsp_pos_q       <= pos_ext[nhs_pkg::POS_W-1:0];
      end else begin
        rsp_cur_valid_q <= 1'b0;
        rsp_tag_q       <= '0;
        rsp_hour_q      <= '0;
        rsp_minute_q    <= '0;
        rsp_second_q    <= '0;
        rsp_pos_q       <= '0;
      end
    end
  end

  always_comb begin
    cursor_d    = cursor_q;
    count_d     = count_q;
    idx_d       = idx_q;
    status_d    = status_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_load    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = rdata_q;
    rd_addr     = cursor_q;
    case (uop_i)
      nhs_pkg::UOP_NOP: ;
      nhs_pkg::UOP_VISIT: begin
        if (keep >= NW'(HISTORY_DEPTH)) begin
          status_d = nhs_pkg::ST_FULL;
        end else begin
          status_d = nhs_pkg::ST_OK;
          wr_en    = 1'b1;
          wr_addr  = keep[CW-1:0];
          wr_data  = {tag_q, hour_q, minute_q, second_q};
          count_d  = keep + NW'(1);
          cursor_d = keep[CW-1:0];
        end
      end
      nhs_pkg::UOP_BACK: begin
        if (count_q != '0 && cursor_q != '0) begin
          status_d = nhs_pkg::ST_OK;
          cursor_d = cursor_q - CW'(1);
        end else begin
          status_d = nhs_pkg::ST_NO_PREV;
        end
      end
      nhs_pkg::UOP_FORWARD: begin
        if (count_q != '0 && (cursor_ext + NW'(1)) < count_q) begin
          status_d = nhs_pkg::ST_OK;
          cursor_d = cursor_q + CW'(1);
        end else begin
          status_d = nhs_pkg::ST_NO_FWD;
        end
      end
      nhs_pkg::UOP_DEL_START: begin
        idx_d    = cursor_q;
        status_d = (count_q == '0) ? nhs_pkg::ST_EMPTY : nhs_pkg::ST_OK;
      end
      nhs_pkg::UOP_SHIFT_RD: begin
        rd_addr = idx_next[CW-1:0];
      end
      nhs_pkg::UOP_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rdata_q;
        idx_d   = idx_next[CW-1:0];
      end
      nhs_pkg::UOP_DEL_FIN: begin
        count_d = count_q - NW'(1);
        if (cursor_q != '0) begin
          cursor_d = cursor_q - CW'(1);
        end
        if (count_q == NW'(1)) begin
          cursor_d = '0;
        end
      end
      nhs_pkg::UOP_READ_CUR: begin
        rd_addr = cursor_q;
      end
      nhs_pkg::UOP_RESPOND: begin
        rsp_load    = 1'b1;
        rsp_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign flags_o.empty    = (count_q == '0);
  assign flags_o.no_next  = !(idx_next < count_q);
  assign flags_o.out_busy = rsp_valid_q && !rsp_ready_i;

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_status_o      = rsp_status_q;
  assign rsp_cur_valid_o   = rsp_cur_valid_q;
  assign rsp_cur_tag_o     = rsp_tag_q;
  assign rsp_cur_hour_o    = rsp_hour_q;
  assign rsp_cur_minute_o  = rsp_minute_q;
  assign rsp_cur_second_o  = rsp_second_q;
  assign rsp_cursor_pos_o  = rsp_pos_q;
  assign rsp_entry_count_o = rsp_count_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (cursor_ext < count_q))
    else $error("cursor beyond held entries");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(HISTORY_DEPTH))
    else $error("entry count above depth");

  a_empty_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (cursor_q == '0))
    else $error("cursor not cleared on empty history");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(uop_i) == nhs_pkg::UOP_RESPOND))
    else $error("response raised outside respond step");

  a_rsp_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uop_i == nhs_pkg::UOP_RESPOND) |-> (!rsp_valid_q || rsp_ready_i))
    else $error("response overwritten before taken");

endmodule
